// ----- rtl/trap_occupancy_implicit_step_top_macros.svh -----
// assertion macros for the trapped-charge update block
`ifndef TRAP_OCCUPANCY_IMPLICIT_STEP_TOP_MACROS_SVH
`define TRAP_OCCUPANCY_IMPLICIT_STEP_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define TOCC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tocc: implication check failed");
// fixed-delay implication
`define TOCC_ASSERT_DLY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("tocc: latency check failed");
`else
`define TOCC_ASSERT_IMP(label, ante, cons)
`define TOCC_ASSERT_DLY(label, ante, dly, cons)
`endif
`endif

// ----- rtl/tocc_pkg.sv -----
`default_nettype none
package tocc_pkg;
	localparam int FRAC_BITS = 24;
	localparam int WORD_W = 32;
	localparam int MAG_W = 62;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = WORD_W;
	localparam int UP_SHIFT = WORD_W - FRAC_BITS;
	localparam int LATENCY = 9 + DIV_STEPS;
	localparam logic [MAG_W-1:0] SAT_MAX = {MAG_W{1'b1}};
	localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;
	localparam logic [63:0] HI_LIMIT = 64'(1) << (30 + FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_STEP = 3'd0,
		CFG_CARRIER_IS_HOLE = 3'd1,
		CFG_B2T_EN = 3'd2,
		CFG_T2B_EN = 3'd3,
		CFG_PF_EN = 3'd4
	} cfg_idx_t;

	// word handed to the divider
	typedef struct packed {
		logic bad;
		logic negn;
		logic ovf;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
	} tocc_div_in_t;

	// word coming back from the divider
	typedef struct packed {
		logic bad;
		logic negn;
		logic ovf;
		logic [WORD_W-1:0] quo;
	} tocc_div_out_t;

	// clamp a sum to the magnitude range
	function automatic logic [MAG_W-1:0] sat62(input logic [63:0] s);
		logic [MAG_W-1:0] r;
		r = (s > 64'(SAT_MAX)) ? SAT_MAX : s[MAG_W-1:0];
		return r;
	endfunction

	// combine high and low partial products of a fixed-point multiply
	function automatic logic [MAG_W-1:0] mulq_fix(input logic [MAG_W-1:0] hi,
			input logic [63:0] lo);
		logic [63:0] s;
		logic [MAG_W-1:0] r;
		s = (64'(hi) << UP_SHIFT) + (lo >> FRAC_BITS);
		if (64'(hi) >= HI_LIMIT) begin
			r = SAT_MAX;
		end else begin
			r = sat62(s);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/trap_occupancy_implicit_step_top.sv -----
// Trapped-charge implicit-Euler update, one mesh vertex per word.
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0 time step, 1 hole carrier, 2 band-to-trap, 3 trap-to-band, 4 Poole-Frenkel);
// unused indexes are ignored. Write only while no vertex is in flight.
// Input: a vertex word is taken at a clock edge with start high and busy low.
// busy stays low, so a new vertex can be taken in every cycle.
// Output: done is high for one cycle with trapped_new, saturated and
// bad_denominator; the receiver must take it in that cycle.
// Pipeline: done rises after the vertex has passed 8 multiply and sum stages,
// 32 divider stages and one output register.
// Throughput: one vertex per cycle, set by the one-bit-per-stage divider.
// Reset: clears all valid bits and loads the registers with a time step of 1.0,
// electron traps, all optional terms off. Words in flight are dropped.
`default_nettype none
`include "trap_occupancy_implicit_step_top_macros.svh"
module trap_occupancy_implicit_step_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [tocc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tocc_pkg::WORD_W-1:0] cfg_data,
	input wire logic start,
	output logic busy,
	input wire logic [31:0] capture_coeff,
	input wire logic [31:0] free_density,
	input wire logic [31:0] trap_density,
	input wire logic [31:0] trapped_last,
	input wire logic [31:0] srh_emission,
	input wire logic signed [31:0] b2t_coeff,
	input wire logic [31:0] t2b_emission,
	input wire logic [31:0] pf_emission,
	output logic done,
	output logic [31:0] trapped_new,
	output logic saturated,
	output logic bad_denominator
);
	localparam int MW = tocc_pkg::MAG_W;
	localparam int FB = tocc_pkg::FRAC_BITS;

	logic [31:0] time_step_q;
	logic hole_q, b2t_en_q, t2b_en_q, pf_en_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic accept;

	// stage 1 payload
	logic [31:0] cap_s1, fre_s1, trp_s1, last_s1, srh_s1, t2b_s1, pf_s1, mag_s1;
	logic neg_s1, use_b_s1, use_t2b_s1, use_pf_s1, ele_s1;
	// stage 2 payload
	logic [MW-1:0] tc_s2, srh_s2, t2b_s2, pf_s2, bd_s2;
	logic [31:0] fre_s2, trp_s2, last_s2;
	logic neg_s2, use_b_s2;
	// stage 3 payload
	logic [MW-1:0] cfh_s3, bh_s3, dneg_s3;
	logic [63:0] cfl_s3, bl_s3, dsum_s3;
	logic [31:0] trp_s3, last_s3;
	logic neg_s3, use_b_s3;
	// stage 4 payload
	logic [MW-1:0] cf_s4, bdt_s4, dneg_s4;
	logic [63:0] dsum_s4;
	logic [31:0] trp_s4, last_s4;
	logic neg_s4, use_b_s4;
	// stage 5 payload
	logic [MW-1:0] cnh_s5, dpos_s5, nneg_s5, dneg_s5;
	logic [63:0] cnl_s5, nacc_s5;
	// stage 6 payload
	logic [MW-1:0] npos_s6, dpos_s6, nneg_s6, dneg_s6;
	// stage 7 payload
	logic [MW-1:0] n_s7, d_s7;
	logic bad_s7, negn_s7;
	// stage 8 payload
	tocc_pkg::tocc_div_in_t din_s8;

	logic div_valid;
	tocc_pkg::tocc_div_out_t div_out;
	logic done_q, sat_q, bad_q;
	logic [31:0] res_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 32'(tocc_pkg::ONE_Q);
			hole_q <= 1'b0;
			b2t_en_q <= 1'b0;
			t2b_en_q <= 1'b0;
			pf_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (tocc_pkg::cfg_idx_t'(cfg_index))
				tocc_pkg::CFG_TIME_STEP: time_step_q <= cfg_data;
				tocc_pkg::CFG_CARRIER_IS_HOLE: hole_q <= cfg_data[0];
				tocc_pkg::CFG_B2T_EN: b2t_en_q <= cfg_data[0];
				tocc_pkg::CFG_T2B_EN: t2b_en_q <= cfg_data[0];
				tocc_pkg::CFG_PF_EN: pf_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid bits along the front pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: capture word, band-to-trap magnitude and term enables
	always_ff @(posedge clk) begin
		cap_s1 <= capture_coeff;
		fre_s1 <= free_density;
		trp_s1 <= trap_density;
		last_s1 <= trapped_last;
		srh_s1 <= srh_emission;
		t2b_s1 <= t2b_emission;
		pf_s1 <= pf_emission;
		neg_s1 <= b2t_coeff[31];
		mag_s1 <= b2t_coeff[31] ? (32'd0 - b2t_coeff) : b2t_coeff;
		ele_s1 <= !hole_q;
		use_b_s1 <= !hole_q && b2t_en_q && (b2t_coeff != 32'sd0);
		use_t2b_s1 <= !hole_q && t2b_en_q;
		use_pf_s1 <= !hole_q && pf_en_q;
	end

	// stage 2: products with the time step
	always_ff @(posedge clk) begin
		tc_s2 <= MW'((64'(time_step_q) * 64'(cap_s1)) >> FB);
		srh_s2 <= ele_s1 ? MW'((64'(time_step_q) * 64'(srh_s1)) >> FB) : '0;
		t2b_s2 <= use_t2b_s1 ? MW'((64'(time_step_q) * 64'(t2b_s1)) >> FB) : '0;
		pf_s2 <= use_pf_s1 ? MW'((64'(time_step_q) * 64'(pf_s1)) >> FB) : '0;
		bd_s2 <= use_b_s1 ? MW'((64'(time_step_q) * 64'(mag_s1)) >> FB) : '0;
		fre_s2 <= fre_s1;
		trp_s2 <= trp_s1;
		last_s2 <= last_s1;
		neg_s2 <= neg_s1;
		use_b_s2 <= use_b_s1;
	end

	// stage 3: partial products for capture and band-to-trap terms, denominator sum
	always_ff @(posedge clk) begin
		cfh_s3 <= MW'(64'(tc_s2[MW-1:32]) * 64'(fre_s2));
		cfl_s3 <= 64'(tc_s2[31:0]) * 64'(fre_s2);
		bh_s3 <= MW'(64'(bd_s2[MW-1:32]) * 64'(trp_s2));
		bl_s3 <= 64'(bd_s2[31:0]) * 64'(trp_s2);
		dsum_s3 <= tocc_pkg::ONE_Q + 64'(srh_s2) + 64'(t2b_s2) + 64'(pf_s2)
			+ ((use_b_s2 && neg_s2) ? 64'(bd_s2) : 64'd0);
		dneg_s3 <= (use_b_s2 && !neg_s2) ? bd_s2 : '0;
		trp_s3 <= trp_s2;
		last_s3 <= last_s2;
		neg_s3 <= neg_s2;
		use_b_s3 <= use_b_s2;
	end

	// stage 4: finish capture rate and band-to-trap numerator term
	always_ff @(posedge clk) begin
		cf_s4 <= tocc_pkg::mulq_fix(cfh_s3, cfl_s3);
		bdt_s4 <= tocc_pkg::mulq_fix(bh_s3, bl_s3);
		dsum_s4 <= dsum_s3;
		dneg_s4 <= dneg_s3;
		trp_s4 <= trp_s3;
		last_s4 <= last_s3;
		neg_s4 <= neg_s3;
		use_b_s4 <= use_b_s3;
	end

	// stage 5: capture times trap density, positive denominator
	always_ff @(posedge clk) begin
		cnh_s5 <= MW'(64'(cf_s4[MW-1:32]) * 64'(trp_s4));
		cnl_s5 <= 64'(cf_s4[31:0]) * 64'(trp_s4);
		dpos_s5 <= tocc_pkg::sat62(dsum_s4 + 64'(cf_s4));
		nacc_s5 <= 64'(last_s4) + ((use_b_s4 && neg_s4) ? 64'(bdt_s4) : 64'd0);
		nneg_s5 <= (use_b_s4 && !neg_s4) ? bdt_s4 : '0;
		dneg_s5 <= dneg_s4;
	end

	// stage 6: positive numerator
	always_ff @(posedge clk) begin
		npos_s6 <= tocc_pkg::sat62(nacc_s5 + 64'(tocc_pkg::mulq_fix(cnh_s5, cnl_s5)));
		dpos_s6 <= dpos_s5;
		nneg_s6 <= nneg_s5;
		dneg_s6 <= dneg_s5;
	end

	// stage 7: net numerator and denominator, sign checks
	always_ff @(posedge clk) begin
		bad_s7 <= (dpos_s6 <= dneg_s6);
		negn_s7 <= (npos_s6 < nneg_s6);
		d_s7 <= dpos_s6 - dneg_s6;
		n_s7 <= npos_s6 - nneg_s6;
	end

	// stage 8: integer part overflow check
	always_ff @(posedge clk) begin
		din_s8.bad <= bad_s7;
		din_s8.negn <= negn_s7;
		din_s8.ovf <= ({{tocc_pkg::UP_SHIFT{1'b0}}, n_s7}
			>= {d_s7, {tocc_pkg::UP_SHIFT{1'b0}}});
		din_s8.num <= n_s7;
		din_s8.den <= d_s7;
	end

	tocc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s8),
		.din(din_s8),
		.out_valid(div_valid),
		.dout(div_out)
	);

	// result register with saturation and bad denominator cases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		bad_q <= div_out.bad;
		sat_q <= !div_out.bad && (div_out.negn || div_out.ovf);
		if (div_out.bad || div_out.negn) begin
			res_q <= '0;
		end else if (div_out.ovf) begin
			res_q <= '1;
		end else begin
			res_q <= div_out.quo;
		end
	end

	assign done = done_q;
	assign trapped_new = res_q;
	assign saturated = sat_q;
	assign bad_denominator = bad_q;

	`TOCC_ASSERT_IMP(a_bad_zero, done && bad_denominator, (trapped_new == 32'd0) && !saturated)
	`TOCC_ASSERT_IMP(a_sat_ends, done && saturated, (trapped_new == 32'd0) || (trapped_new == '1))
	`TOCC_ASSERT_DLY(a_latency, start && !busy, 41, done)
endmodule
`default_nettype wire

// ----- rtl/tocc_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per stage, fully pipelined
module tocc_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire tocc_pkg::tocc_div_in_t din,
	output logic out_valid,
	output tocc_pkg::tocc_div_out_t dout
);
	typedef struct packed {
		logic bad;
		logic negn;
		logic ovf;
		logic [tocc_pkg::MAG_W-1:0] rem;
		logic [tocc_pkg::WORD_W-1:0] low;
		logic [tocc_pkg::WORD_W-1:0] quo;
		logic [tocc_pkg::MAG_W-1:0] den;
	} tocc_stage_t;

	logic [tocc_pkg::MAG_W+tocc_pkg::FRAC_BITS-1:0] nsh;
	tocc_stage_t st [0:tocc_pkg::DIV_STEPS];
	logic vld [0:tocc_pkg::DIV_STEPS];

	// numerator scaled by the fraction bits, split into start remainder and bits to feed
	assign nsh = {din.num, {tocc_pkg::FRAC_BITS{1'b0}}};
	always_comb begin
		st[0].bad = din.bad;
		st[0].negn = din.negn;
		st[0].ovf = din.ovf;
		st[0].rem = tocc_pkg::MAG_W'(nsh[tocc_pkg::MAG_W+tocc_pkg::FRAC_BITS-1:tocc_pkg::WORD_W]);
		st[0].low = nsh[tocc_pkg::WORD_W-1:0];
		st[0].quo = '0;
		st[0].den = din.den;
		vld[0] = in_valid;
	end

	for (genvar i = 0; i < tocc_pkg::DIV_STEPS; i++) begin : g_step
		logic [tocc_pkg::MAG_W:0] r2;
		logic [tocc_pkg::MAG_W:0] diff;
		logic ge;

		// shift in one bit, subtract if it fits
		always_comb begin
			r2 = {st[i].rem, st[i].low[tocc_pkg::WORD_W-1]};
			diff = r2 - {1'b0, st[i].den};
			ge = (r2 >= {1'b0, st[i].den});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			st[i+1].bad <= st[i].bad;
			st[i+1].negn <= st[i].negn;
			st[i+1].ovf <= st[i].ovf;
			st[i+1].rem <= ge ? diff[tocc_pkg::MAG_W-1:0] : r2[tocc_pkg::MAG_W-1:0];
			st[i+1].low <= {st[i].low[tocc_pkg::WORD_W-2:0], 1'b0};
			st[i+1].quo <= {st[i].quo[tocc_pkg::WORD_W-2:0], ge};
			st[i+1].den <= st[i].den;
		end
	end

	assign out_valid = vld[tocc_pkg::DIV_STEPS];
	assign dout.bad = st[tocc_pkg::DIV_STEPS].bad;
	assign dout.negn = st[tocc_pkg::DIV_STEPS].negn;
	assign dout.ovf = st[tocc_pkg::DIV_STEPS].ovf;
	assign dout.quo = st[tocc_pkg::DIV_STEPS].quo;
endmodule
`default_nettype wire
